>>> rtl/cosl_pkg.sv
// Shared types and constants for the cosine leader clustering core.
package cosl_pkg;

    localparam int FEATURE_BITS     = 16;
    localparam int THR_BITS         = 15;
    localparam int COUNT_BITS       = 24;
    localparam int SUM_BITS         = 40;
    localparam int TICK_BITS        = 32;
    localparam int MUL_DIGIT        = 8;
    localparam int DIM_DEF          = 8;
    localparam int MAX_CLUSTERS_DEF = 64;

    localparam logic [THR_BITS-1:0]   THR_RESET = 15'd22938;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        ST_MATCH = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2,
        ST_LEN   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_PREPW,
        S_DOT,
        S_EVAL,
        S_M1,
        S_M3,
        S_M4,
        S_M5,
        S_RESOLVE,
        S_CREATE,
        S_UPD_INFO,
        S_UPD_RD,
        S_UPD_SUM,
        S_UPD_DIV
    } state_t;

endpackage

>>> rtl/cosine_leader_clustering_core.sv
// Online leader clustering of feature vectors by cosine similarity, top level.
// Elements stream in one per transaction. On the final element the core scans every stored
// cluster, reading the mean memory to form the dot product and norm, then for clusters with a
// positive dot product runs two or four passes of the shared 8-bit-digit multiplier for the
// exact squared compare. A match then rebuilds each mean element with the serial divider,
// unless the member count is saturated; a new cluster copies the vector into the mean and sum
// memories. One result transaction follows each final element; the next vector may stream in
// while that result waits.
module cosine_leader_clustering_core #(
    parameter int DIM          = cosl_pkg::DIM_DEF,
    parameter int MAX_CLUSTERS = cosl_pkg::MAX_CLUSTERS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [cosl_pkg::FEATURE_BITS-1:0] feature_value,
    input  logic                                   last_feature,
    input  logic [cosl_pkg::TICK_BITS-1:0]         tick,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [$clog2(MAX_CLUSTERS)-1:0]        cluster_index,
    output logic [1:0]                             status,
    output logic [cosl_pkg::COUNT_BITS-1:0]        member_total,
    input  logic                                   cfg_we,
    input  logic [cosl_pkg::THR_BITS-1:0]          cfg_wdata
);

    localparam int FB   = cosl_pkg::FEATURE_BITS;
    localparam int CB   = cosl_pkg::COUNT_BITS;
    localparam int SB   = cosl_pkg::SUM_BITS;
    localparam int TB   = cosl_pkg::TICK_BITS;
    localparam int TH   = cosl_pkg::THR_BITS;
    localparam int NW   = 31 + $clog2(DIM);
    localparam int DW   = NW + 1;
    localparam int AW   = 2 * NW;
    localparam int PW   = 3 * NW;
    localparam int ECW  = $clog2(DIM + 2);
    localparam int VAW  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int IW   = $clog2(MAX_CLUSTERS);
    localparam int CCW  = $clog2(MAX_CLUSTERS + 1);
    localparam int BW   = $clog2(MAX_CLUSTERS * DIM);
    localparam int IFW  = TB + CB;

    localparam logic [ECW-1:0] DIM_C  = ECW'(DIM);
    localparam logic [ECW-1:0] OVER_C = ECW'(DIM + 1);
    localparam logic [CCW-1:0] MAX_C  = CCW'(MAX_CLUSTERS);

    cosl_pkg::state_t state_reg, state_next;

    logic [ECW-1:0]        ec_reg, ec_next, ec_new;
    logic [NW-1:0]         na_reg, na_next;
    logic [TH-1:0]         thr_reg;
    logic [2*TH-1:0]       thr2_reg, thr2_next;
    logic [TB-1:0]         tick_reg, tick_next;
    logic [CCW-1:0]        cc_reg, cc_next;
    logic [CCW-1:0]        c_reg, c_next;
    logic [BW-1:0]         base_reg, base_next;
    logic [ECW-1:0]        idx_reg, idx_next;
    logic [ECW-1:0]        wa_reg, wa_next;
    logic                  rdv_reg, rdv_next;
    logic signed [DW-1:0]  dot_reg, dot_next;
    logic [NW-1:0]         nb_reg, nb_next;
    logic [AW-1:0]         tn_reg, tn_next;
    logic [AW-1:0]         p1_reg, p1_next;
    logic [PW-1:0]         p4_reg, p4_next;
    logic                  hb_reg, hb_next;
    logic [IW-1:0]         best_reg, best_next;
    logic [BW-1:0]         bbase_reg, bbase_next;
    logic [AW-1:0]         bdd_reg, bdd_next;
    logic [NW-1:0]         bnb_reg, bnb_next;
    logic [CB-1:0]         cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [IW-1:0]         out_idx_reg, out_idx_next;
    cosl_pkg::status_t     out_st_reg, out_st_next;
    logic [CB-1:0]         out_tot_reg, out_tot_next;
    logic                  out_load;

    logic                  vec_we;
    logic [VAW-1:0]        vec_waddr, vec_raddr;
    logic [FB-1:0]         vec_wdata, vec_rdata;
    logic                  mean_we;
    logic [BW-1:0]         mean_waddr, mean_raddr;
    logic [FB-1:0]         mean_wdata, mean_rdata;
    logic                  sum_we;
    logic [BW-1:0]         sum_waddr, sum_raddr;
    logic [SB-1:0]         sum_wdata, sum_rdata;
    logic                  info_we;
    logic [IW-1:0]         info_waddr, info_raddr;
    logic [IFW-1:0]        info_wdata, info_rdata;

    logic                  mul_start, mul_done;
    logic [AW-1:0]         mul_a;
    logic [NW-1:0]         mul_b;
    logic [PW-1:0]         mul_prod;
    logic                  div_start, div_done;
    logic [SB-1:0]         div_num;
    logic [FB-1:0]         div_q;

    logic                  accept, advance, take;
    logic signed [2*FB-1:0] sq_in, prod_vm, sq_m;
    logic [NW-1:0]         ud;
    logic [PW-1:0]         lhs;
    logic [SB-1:0]         vec_sext;
    logic [CB-1:0]         info_cnt;

    assign sq_in    = feature_value * feature_value;
    assign prod_vm  = $signed(vec_rdata) * $signed(mean_rdata);
    assign sq_m     = $signed(mean_rdata) * $signed(mean_rdata);
    assign ud       = dot_reg[NW-1:0];
    assign lhs      = PW'(p1_reg) << 30;
    assign vec_sext = {{(SB - FB){vec_rdata[FB-1]}}, vec_rdata};
    assign info_cnt = info_rdata[CB-1:0];

    assign in_ready = (state_reg == cosl_pkg::S_IDLE)
                      && (!last_feature || !out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        ec_next      = ec_reg;
        ec_new       = ec_reg;
        na_next      = na_reg;
        thr2_next    = thr2_reg;
        tick_next    = tick_reg;
        cc_next      = cc_reg;
        c_next       = c_reg;
        base_next    = base_reg;
        idx_next     = idx_reg;
        wa_next      = wa_reg;
        rdv_next     = 1'b0;
        dot_next     = dot_reg;
        nb_next      = nb_reg;
        tn_next      = tn_reg;
        p1_next      = p1_reg;
        p4_next      = p4_reg;
        hb_next      = hb_reg;
        best_next    = best_reg;
        bbase_next   = bbase_reg;
        bdd_next     = bdd_reg;
        bnb_next     = bnb_reg;
        cnt_next     = cnt_reg;
        out_load     = 1'b0;
        out_idx_next = out_idx_reg;
        out_st_next  = out_st_reg;
        out_tot_next = out_tot_reg;
        vec_we       = 1'b0;
        vec_waddr    = ec_reg[VAW-1:0];
        vec_wdata    = feature_value;
        vec_raddr    = idx_reg[VAW-1:0];
        mean_we      = 1'b0;
        mean_waddr   = base_reg + BW'(wa_reg);
        mean_wdata   = vec_rdata;
        mean_raddr   = base_reg + BW'(idx_reg);
        sum_we       = 1'b0;
        sum_waddr    = base_reg + BW'(wa_reg);
        sum_wdata    = vec_sext;
        sum_raddr    = bbase_reg + BW'(idx_reg);
        info_we      = 1'b0;
        info_waddr   = best_reg;
        info_wdata   = {tick_reg, cnt_reg};
        info_raddr   = best_reg;
        mul_start    = 1'b0;
        mul_a        = tn_reg;
        mul_b        = nb_reg;
        div_start    = 1'b0;
        div_num      = sum_rdata + vec_sext;
        advance      = 1'b0;
        take         = 1'b0;

        case (state_reg)
            cosl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (ec_reg < DIM_C)
                    begin
                        vec_we  = 1'b1;
                        na_next = ((ec_reg == '0) ? '0 : na_reg) + NW'($unsigned(sq_in));
                        ec_new  = ec_reg + ECW'(1);
                    end
                    else
                    begin
                        ec_new = OVER_C;
                    end
                    ec_next = ec_new;
                    if (last_feature)
                    begin
                        ec_next = '0;
                        if (ec_new != DIM_C)
                        begin
                            out_load     = 1'b1;
                            out_idx_next = '0;
                            out_st_next  = cosl_pkg::ST_LEN;
                            out_tot_next = '0;
                        end
                        else
                        begin
                            tick_next  = tick;
                            thr2_next  = thr_reg * thr_reg;
                            state_next = cosl_pkg::S_PREP;
                        end
                    end
                end
            end
            cosl_pkg::S_PREP:
            begin
                mul_start  = 1'b1;
                mul_a      = AW'(thr2_reg);
                mul_b      = na_reg;
                state_next = cosl_pkg::S_PREPW;
            end
            cosl_pkg::S_PREPW:
            begin
                if (mul_done)
                begin
                    tn_next   = mul_prod[AW-1:0];
                    c_next    = '0;
                    base_next = '0;
                    hb_next   = 1'b0;
                    idx_next  = '0;
                    dot_next  = '0;
                    nb_next   = '0;
                    if (cc_reg == '0)
                    begin
                        state_next = cosl_pkg::S_RESOLVE;
                    end
                    else
                    begin
                        state_next = cosl_pkg::S_DOT;
                    end
                end
            end
            cosl_pkg::S_DOT:
            begin
                if (idx_reg < DIM_C)
                begin
                    idx_next = idx_reg + ECW'(1);
                    rdv_next = 1'b1;
                end
                if (rdv_reg)
                begin
                    dot_next = dot_reg + DW'(prod_vm);
                    nb_next  = nb_reg + NW'($unsigned(sq_m));
                end
                if (idx_reg == DIM_C && !rdv_reg)
                begin
                    state_next = cosl_pkg::S_EVAL;
                end
            end
            cosl_pkg::S_EVAL:
            begin
                if (dot_reg[DW-1] || dot_reg == '0 || na_reg == '0 || nb_reg == '0)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = AW'(ud);
                    mul_b      = ud;
                    state_next = cosl_pkg::S_M1;
                end
            end
            cosl_pkg::S_M1:
            begin
                if (mul_done)
                begin
                    p1_next    = mul_prod[AW-1:0];
                    mul_start  = 1'b1;
                    state_next = cosl_pkg::S_M3;
                end
            end
            cosl_pkg::S_M3:
            begin
                if (mul_done)
                begin
                    if (lhs > mul_prod)
                    begin
                        if (!hb_reg)
                        begin
                            take    = 1'b1;
                            advance = 1'b1;
                        end
                        else
                        begin
                            mul_start  = 1'b1;
                            mul_a      = p1_reg;
                            mul_b      = bnb_reg;
                            state_next = cosl_pkg::S_M4;
                        end
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
            end
            cosl_pkg::S_M4:
            begin
                if (mul_done)
                begin
                    p4_next    = mul_prod;
                    mul_start  = 1'b1;
                    mul_a      = bdd_reg;
                    state_next = cosl_pkg::S_M5;
                end
            end
            cosl_pkg::S_M5:
            begin
                if (mul_done)
                begin
                    take    = (p4_reg > mul_prod);
                    advance = 1'b1;
                end
            end
            cosl_pkg::S_RESOLVE:
            begin
                idx_next = '0;
                if (hb_reg)
                begin
                    state_next = cosl_pkg::S_UPD_INFO;
                end
                else if (cc_reg == MAX_C)
                begin
                    out_load     = 1'b1;
                    out_idx_next = '0;
                    out_st_next  = cosl_pkg::ST_FULL;
                    out_tot_next = '0;
                    state_next   = cosl_pkg::S_IDLE;
                end
                else
                begin
                    info_we    = 1'b1;
                    info_waddr = cc_reg[IW-1:0];
                    info_wdata = {tick_reg, CB'(1)};
                    best_next  = cc_reg[IW-1:0];
                    cc_next    = cc_reg + CCW'(1);
                    state_next = cosl_pkg::S_CREATE;
                end
            end
            cosl_pkg::S_CREATE:
            begin
                if (idx_reg < DIM_C)
                begin
                    wa_next  = idx_reg;
                    idx_next = idx_reg + ECW'(1);
                    rdv_next = 1'b1;
                end
                if (rdv_reg)
                begin
                    sum_we  = 1'b1;
                    mean_we = 1'b1;
                end
                if (idx_reg == DIM_C && !rdv_reg)
                begin
                    out_load     = 1'b1;
                    out_idx_next = best_reg;
                    out_st_next  = cosl_pkg::ST_NEW;
                    out_tot_next = CB'(1);
                    state_next   = cosl_pkg::S_IDLE;
                end
            end
            cosl_pkg::S_UPD_INFO:
            begin
                info_we = 1'b1;
                if (info_cnt == cosl_pkg::COUNT_MAX)
                begin
                    info_wdata   = {tick_reg, info_cnt};
                    out_load     = 1'b1;
                    out_idx_next = best_reg;
                    out_st_next  = cosl_pkg::ST_MATCH;
                    out_tot_next = info_cnt;
                    state_next   = cosl_pkg::S_IDLE;
                end
                else
                begin
                    cnt_next   = info_cnt + CB'(1);
                    info_wdata = {tick_reg, info_cnt + CB'(1)};
                    state_next = cosl_pkg::S_UPD_RD;
                end
            end
            cosl_pkg::S_UPD_RD:
            begin
                state_next = cosl_pkg::S_UPD_SUM;
            end
            cosl_pkg::S_UPD_SUM:
            begin
                sum_we     = 1'b1;
                sum_waddr  = bbase_reg + BW'(idx_reg);
                sum_wdata  = div_num;
                div_start  = 1'b1;
                state_next = cosl_pkg::S_UPD_DIV;
            end
            cosl_pkg::S_UPD_DIV:
            begin
                if (div_done)
                begin
                    mean_we    = 1'b1;
                    mean_waddr = bbase_reg + BW'(idx_reg);
                    mean_wdata = div_q;
                    idx_next   = idx_reg + ECW'(1);
                    if (idx_reg + ECW'(1) == DIM_C)
                    begin
                        out_load     = 1'b1;
                        out_idx_next = best_reg;
                        out_st_next  = cosl_pkg::ST_MATCH;
                        out_tot_next = cnt_reg;
                        state_next   = cosl_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = cosl_pkg::S_UPD_RD;
                    end
                end
            end
            default:
            begin
                state_next = cosl_pkg::S_IDLE;
            end
        endcase

        if (take)
        begin
            hb_next    = 1'b1;
            best_next  = c_reg[IW-1:0];
            bbase_next = base_reg;
            bdd_next   = p1_reg;
            bnb_next   = nb_reg;
        end
        if (advance)
        begin
            c_next    = c_reg + CCW'(1);
            base_next = base_reg + BW'(DIM);
            idx_next  = '0;
            dot_next  = '0;
            nb_next   = '0;
            if (c_reg + CCW'(1) == cc_reg)
            begin
                state_next = cosl_pkg::S_RESOLVE;
            end
            else
            begin
                state_next = cosl_pkg::S_DOT;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cosl_pkg::S_IDLE;
            ec_reg        <= '0;
            cc_reg        <= '0;
            thr_reg       <= cosl_pkg::THR_RESET;
            rdv_reg       <= 1'b0;
            hb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ec_reg        <= ec_next;
            cc_reg        <= cc_next;
            rdv_reg       <= rdv_next;
            hb_reg        <= hb_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg      <= na_next;
        thr2_reg    <= thr2_next;
        tick_reg    <= tick_next;
        c_reg       <= c_next;
        base_reg    <= base_next;
        idx_reg     <= idx_next;
        wa_reg      <= wa_next;
        dot_reg     <= dot_next;
        nb_reg      <= nb_next;
        tn_reg      <= tn_next;
        p1_reg      <= p1_next;
        p4_reg      <= p4_next;
        best_reg    <= best_next;
        bbase_reg   <= bbase_next;
        bdd_reg     <= bdd_next;
        bnb_reg     <= bnb_next;
        cnt_reg     <= cnt_next;
        out_idx_reg <= out_idx_next;
        out_st_reg  <= out_st_next;
        out_tot_reg <= out_tot_next;
    end

    cosl_ram #(.WIDTH(FB), .DEPTH(DIM)) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (vec_wdata),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    cosl_ram #(.WIDTH(FB), .DEPTH(MAX_CLUSTERS * DIM)) u_mean_ram (
        .clk   (clk),
        .we    (mean_we),
        .waddr (mean_waddr),
        .wdata (mean_wdata),
        .raddr (mean_raddr),
        .rdata (mean_rdata)
    );

    cosl_ram #(.WIDTH(SB), .DEPTH(MAX_CLUSTERS * DIM)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    cosl_ram #(.WIDTH(IFW), .DEPTH(MAX_CLUSTERS)) u_info_ram (
        .clk   (clk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .raddr (info_raddr),
        .rdata (info_rdata)
    );

    cosl_mul #(.A_BITS(AW), .B_BITS(NW), .P_BITS(PW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    cosl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid     = out_valid_reg;
    assign cluster_index = out_idx_reg;
    assign status        = out_st_reg;
    assign member_total  = out_tot_reg;

    a_cc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cc_reg <= MAX_C)
        else $error("cluster count above table size");

    a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ec_reg <= OVER_C)
        else $error("element count out of range");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrites a pending transaction");

    a_mul_gap: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> !mul_done)
        else $error("multiplier finished too early");

    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_st_next == cosl_pkg::ST_FULL) |-> (cc_reg == MAX_C))
        else $error("full status with free slots");

endmodule

>>> rtl/cosl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cosl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/cosl_mul.sv
// Digit-serial unsigned multiplier, one 8-bit digit of b per cycle.
module cosl_mul #(
    parameter int A_BITS = 68,
    parameter int B_BITS = 34,
    parameter int P_BITS = 102
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [A_BITS-1:0] a,
    input  logic [B_BITS-1:0] b,
    output logic              done,
    output logic [P_BITS-1:0] prod
);

    localparam int D     = cosl_pkg::MUL_DIGIT;
    localparam int STEPS = (B_BITS + D - 1) / D;
    localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [P_BITS-1:0]   acc_reg, acc_next;
    logic [P_BITS-1:0]   a_sh_reg, a_sh_next;
    logic [B_BITS-1:0]   b_sh_reg, b_sh_next;
    logic [SCW-1:0]      step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [P_BITS+D-1:0] part;

    assign part = a_sh_reg * b_sh_reg[D-1:0];

    always_comb
    begin
        acc_next  = acc_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_sh_next = P_BITS'(a);
            b_sh_next = b;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + part[P_BITS-1:0];
            a_sh_next = a_sh_reg << D;
            b_sh_next = b_sh_reg >> D;
            step_next = step_reg + SCW'(1);
            if (step_reg == SCW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

>>> rtl/cosl_div.sv
// Restoring divider: signed sum by unsigned count, truncated toward zero.
module cosl_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [cosl_pkg::SUM_BITS-1:0]         dividend,
    input  logic [cosl_pkg::COUNT_BITS-1:0]       divisor,
    output logic                                  done,
    output logic [cosl_pkg::FEATURE_BITS-1:0]     quotient
);

    localparam int SB  = cosl_pkg::SUM_BITS;
    localparam int CB  = cosl_pkg::COUNT_BITS;
    localparam int SCW = $clog2(SB);

    logic [SB-1:0]  mq_reg, mq_next;
    logic [CB-1:0]  rem_reg, rem_next;
    logic [CB-1:0]  d_reg, d_next;
    logic           neg_reg, neg_next;
    logic [SCW-1:0] step_reg, step_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CB:0]    rem_sh;
    logic [CB:0]    rem_sub;
    logic [SB-1:0]  q_full;

    assign rem_sh  = {rem_reg, mq_reg[SB-1]};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_comb
    begin
        mq_next   = mq_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next  = dividend[SB-1];
            mq_next   = dividend[SB-1] ? (~dividend + SB'(1)) : dividend;
            rem_next  = '0;
            d_next    = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, d_reg})
            begin
                rem_next = rem_sub[CB-1:0];
                mq_next  = {mq_reg[SB-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[CB-1:0];
                mq_next  = {mq_reg[SB-2:0], 1'b0};
            end
            step_next = step_reg + SCW'(1);
            if (step_reg == SCW'(SB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mq_reg  <= mq_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign q_full   = neg_reg ? (~mq_reg + SB'(1)) : mq_reg;
    assign quotient = q_full[cosl_pkg::FEATURE_BITS-1:0];
    assign done     = done_reg;

endmodule
